@@ hw/rtl/dau_pkg.sv @@
// Shared constants for the digamma evaluation pipeline.
package dau_pkg;

	localparam int X_W       = 32;
	localparam int PSI_W     = 48;
	localparam int DIV_W     = 33;
	localparam int QUO_W     = 50;
	localparam int NUM_DIV   = 7;
	localparam int LN_ROUNDS = 32;
	localparam int LN_W      = 36;
	localparam int INV_W     = 30;
	localparam int REC_W     = 49;
	localparam int Q_W       = 28;
	localparam int PIPE_LAT  = 63;

	localparam logic [DIV_W-1:0] ONE_Q16 = 33'd65536;
	localparam logic [31:0]      LN2_Q32 = 32'd2977044472;

	localparam logic signed [31:0] COEF_C4 = 32'sd17895697;
	localparam logic signed [31:0] COEF_C3 = 32'sd17043521;
	localparam logic signed [31:0] COEF_C2 = 32'sd35791394;
	localparam logic signed [31:0] COEF_C1 = 32'sd357913941;

	localparam logic [PSI_W-1:0] PSI_MIN = 48'h8000_0000_0000;

endpackage

@@ hw/rtl/dau_div.sv @@
// Pipelined restoring divider giving floor(2^49 / divisor), one quotient bit per stage.
module dau_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [dau_pkg::DIV_W-1:0]  divisor,
	output logic [dau_pkg::QUO_W-1:0]  quotient
);

	localparam int Steps = dau_pkg::QUO_W;
	localparam int DW    = dau_pkg::DIV_W;

	logic [DW-1:0]    rem_s [Steps];
	logic [DW-1:0]    dvs_s [Steps];
	logic [Steps-1:0] quo_s [Steps];

	logic [DW-1:0]    rem_p [Steps];
	logic [DW-1:0]    dvs_p [Steps];
	logic [Steps-1:0] quo_p [Steps];
	logic [DW:0]      trial [Steps];
	logic             fits  [Steps];

	always_comb begin
		for (int j = 0; j < Steps; j++) begin
			if (j == 0) begin
				rem_p[j] = '0;
				dvs_p[j] = divisor;
				quo_p[j] = '0;
			end else begin
				rem_p[j] = rem_s[j-1];
				dvs_p[j] = dvs_s[j-1];
				quo_p[j] = quo_s[j-1];
			end
			// The dividend is a single one in its top bit, followed by zeros.
			trial[j] = {rem_p[j], 1'(j == 0)};
			fits[j]  = trial[j] >= {1'b0, dvs_p[j]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < Steps; j++) begin
				if (fits[j]) begin
					rem_s[j] <= DW'(trial[j] - {1'b0, dvs_p[j]});
				end else begin
					rem_s[j] <= trial[j][DW-1:0];
				end
				dvs_s[j] <= dvs_p[j];
				quo_s[j] <= {quo_p[j][Steps-2:0], fits[j]};
			end
		end
	end

	assign quotient = quo_s[Steps-1];

endmodule

@@ hw/rtl/dau_ln.sv @@
// Pipelined natural logarithm of a Q16.16 value by repeated squaring, result in Q32.
module dau_ln (
	input  logic                      clk,
	input  logic                      en,
	input  logic [dau_pkg::DIV_W-1:0] s_in,
	output logic [dau_pkg::LN_W-1:0]  ln_out
);

	localparam int Rounds = dau_pkg::LN_ROUNDS;
	localparam int LW     = dau_pkg::LN_W;

	logic [31:0] m_s  [Rounds+1];
	logic [31:0] f_s  [Rounds+1];
	logic [4:0]  ex_s [Rounds+1];
	logic [63:0] prod_s34;
	logic [4:0]  ex_s34;
	logic [LW-1:0] ln_s35;

	logic [31:0] norm_m;
	logic [4:0]  norm_ex;
	logic [31:0] sh;
	logic [3:0]  lz;

	logic [63:0] sq   [Rounds];
	logic [31:0] m_n  [Rounds];
	logic [31:0] f_n  [Rounds];
	logic [63:0] ln_rnd;

	// Leading-one normalisation of the argument into [2^31, 2^32).
	always_comb begin
		sh = s_in[31:0];
		lz = '0;
		if (sh[31:24] == '0) begin
			sh = sh << 8;
			lz = lz + 4'd8;
		end
		if (sh[31:28] == '0) begin
			sh = sh << 4;
			lz = lz + 4'd4;
		end
		if (sh[31:30] == '0) begin
			sh = sh << 2;
			lz = lz + 4'd2;
		end
		if (!sh[31]) begin
			sh = sh << 1;
			lz = lz + 4'd1;
		end
		if (s_in[32]) begin
			norm_m  = s_in[32:1];
			norm_ex = 5'd16;
		end else begin
			norm_m  = sh;
			norm_ex = 5'd15 - {1'b0, lz};
		end
	end

	always_comb begin
		for (int r = 0; r < Rounds; r++) begin
			sq[r] = 64'(m_s[r]) * 64'(m_s[r]);
			if (sq[r][63]) begin
				m_n[r] = sq[r][63:32];
			end else begin
				m_n[r] = sq[r][62:31];
			end
			f_n[r] = {f_s[r][30:0], sq[r][63]};
		end
	end

	assign ln_rnd = prod_s34 + 64'h0000_0000_8000_0000;

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]  <= norm_m;
			f_s[0]  <= '0;
			ex_s[0] <= norm_ex;
			for (int r = 0; r < Rounds; r++) begin
				m_s[r+1]  <= m_n[r];
				f_s[r+1]  <= f_n[r];
				ex_s[r+1] <= ex_s[r];
			end
			prod_s34 <= 64'(f_s[Rounds]) * 64'(dau_pkg::LN2_Q32);
			ex_s34   <= ex_s[Rounds];
			ln_s35   <= LW'(ex_s34) * LW'(dau_pkg::LN2_Q32) + LW'(ln_rnd[63:32]);
		end
	end

	assign ln_out = ln_s35;

endmodule

@@ hw/rtl/digamma_asymptotic_unit.sv @@
// Digamma unit: top level with the reciprocal, polynomial and summation stages.
//
// Usage: one argument enters on the slave stream (tdata = x, unsigned Q16.16)
// and one result leaves on the master stream (tdata = digamma(x), signed
// Q23.24; tuser = invalid flag, set for a zero argument with the result at its
// minimum). Requests keep their order.
// The pipeline accepts one request every cycle unless its output stalls. Its
// length is set by the seven bit-serial reciprocal dividers (50 stages each),
// followed by the four-step Horner polynomial, whose multipliers each take a
// stage of their own before the rounded add. The logarithm runs alongside the
// dividers as 32 squaring stages.
// The whole pipeline advances together: while the output holds a result that
// the receiver has not taken, every stage holds and tready falls, so nothing is
// lost or repeated. Asynchronous reset clears the valid bits only; the block
// accepts requests as soon as reset is released.
module digamma_asymptotic_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] x_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [47:0] psi_value
	output logic [0:0]  m_axis_tuser   // [0] invalid
);

	localparam int NDiv  = dau_pkg::NUM_DIV;
	localparam int DW    = dau_pkg::DIV_W;
	localparam int QW    = dau_pkg::QUO_W;
	localparam int Lat   = dau_pkg::PIPE_LAT;
	localparam int LW    = dau_pkg::LN_W;
	localparam int IW    = dau_pkg::INV_W;
	localparam int RW    = dau_pkg::REC_W;
	localparam int QQW   = dau_pkg::Q_W;

	logic adv;
	logic vld_s [Lat];
	logic zero_s [Lat-1];

	logic [DW-1:0] dvs [NDiv];
	logic [QW-1:0] div_q [NDiv];
	logic [LW-1:0] ln_s35;

	logic [LW-1:0] ln_dly_s [16];
	logic [IW-1:0] inv_s51;
	logic [IW-1:0] half_s51;
	logic [RW-1:0] rec_s51 [NDiv-1];

	logic [QW:0]   inv_inc;
	logic [QW-1:0] half_inc;
	logic [QW:0]   rec_inc [NDiv-1];

	logic signed [LW:0] lnhalf_s52;
	logic [RW+1:0]      ra_s52;
	logic [RW+1:0]      rb_s52;
	logic [2*IW-1:0]    qp_s52;
	logic [RW+2:0]      recsum_s53;
	logic [QQW-1:0]     qc_s [7];
	logic [2*IW-1:0]    q_rnd;

	logic signed [LW:0] lnh_dly_s [9];
	logic [RW+2:0]      rs_dly_s [8];

	logic signed [63:0] prod_s54, prod_s56, prod_s58, prod_s60;
	logic signed [31:0] poly_s55, poly_s57, poly_s59, poly_s61;
	logic signed [55:0] psi_s62;
	logic signed [55:0] psi_rnd;
	logic [47:0]        psi_s63;

	function automatic logic signed [31:0] rnd32(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = p + 64'sh0000_0000_8000_0000;
		return t[63:32];
	endfunction

	assign adv           = !vld_s[Lat-1] || m_axis_tready;
	assign s_axis_tready = adv;

	// Divisors x + k for k = 0..6; the last one is the shifted argument.
	always_comb begin
		for (int k = 0; k < NDiv; k++) begin
			dvs[k] = {1'b0, s_axis_tdata} + (DW'(k) << 16);
		end
	end

	for (genvar k = 0; k < NDiv; k++) begin : g_div
		dau_div u_div (
			.clk      (clk),
			.en       (adv),
			.divisor  (dvs[k]),
			.quotient (div_q[k])
		);
	end

	dau_ln u_ln (
		.clk    (clk),
		.en     (adv),
		.s_in   (dvs[NDiv-1]),
		.ln_out (ln_s35)
	);

	// A quotient of 2^49 / d, plus one and halved, is 2^48 / d rounded half up.
	always_comb begin
		inv_inc  = {1'b0, div_q[NDiv-1]} + (QW+1)'(1);
		half_inc = {1'b0, div_q[NDiv-1][QW-1:1]} + QW'(1);
		for (int k = 0; k < NDiv-1; k++) begin
			rec_inc[k] = {1'b0, div_q[k]} + (QW+1)'(1);
		end
	end

	assign q_rnd   = qp_s52 + (2*IW)'(32'h8000_0000);
	assign psi_rnd = psi_s62 + 56'sd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Lat; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= s_axis_tvalid;
			for (int i = 1; i < Lat; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s[0] <= s_axis_tdata == '0;
			for (int i = 1; i < Lat-1; i++) begin
				zero_s[i] <= zero_s[i-1];
			end

			ln_dly_s[0] <= ln_s35;
			for (int i = 1; i < 16; i++) begin
				ln_dly_s[i] <= ln_dly_s[i-1];
			end

			inv_s51  <= inv_inc[IW:1];
			half_s51 <= half_inc[IW:1];
			for (int k = 0; k < NDiv-1; k++) begin
				rec_s51[k] <= rec_inc[k][RW:1];
			end

			lnhalf_s52 <= $signed({1'b0, ln_dly_s[15]}) - $signed((LW+1)'(half_s51));
			ra_s52     <= (RW+2)'(rec_s51[0]) + (RW+2)'(rec_s51[1]) + (RW+2)'(rec_s51[2]);
			rb_s52     <= (RW+2)'(rec_s51[3]) + (RW+2)'(rec_s51[4]) + (RW+2)'(rec_s51[5]);
			qp_s52     <= (2*IW)'(inv_s51) * (2*IW)'(inv_s51);

			recsum_s53 <= (RW+3)'(ra_s52) + (RW+3)'(rb_s52);
			qc_s[0]    <= q_rnd[QQW+31:32];
			for (int i = 1; i < 7; i++) begin
				qc_s[i] <= qc_s[i-1];
			end

			lnh_dly_s[0] <= lnhalf_s52;
			for (int i = 1; i < 9; i++) begin
				lnh_dly_s[i] <= lnh_dly_s[i-1];
			end
			rs_dly_s[0] <= recsum_s53;
			for (int i = 1; i < 8; i++) begin
				rs_dly_s[i] <= rs_dly_s[i-1];
			end

			// Horner steps in 1/s^2, each product registered before its rounding add.
			prod_s54 <= 64'(dau_pkg::COEF_C4 * $signed({1'b0, qc_s[0]}));
			poly_s55 <= rnd32(prod_s54) - dau_pkg::COEF_C3;
			prod_s56 <= 64'(poly_s55 * $signed({1'b0, qc_s[2]}));
			poly_s57 <= rnd32(prod_s56) + dau_pkg::COEF_C2;
			prod_s58 <= 64'(poly_s57 * $signed({1'b0, qc_s[4]}));
			poly_s59 <= rnd32(prod_s58) - dau_pkg::COEF_C1;
			prod_s60 <= 64'(poly_s59 * $signed({1'b0, qc_s[6]}));
			poly_s61 <= rnd32(prod_s60);

			psi_s62 <= 56'(lnh_dly_s[8]) + 56'(poly_s61) - $signed(56'(rs_dly_s[7]));

			if (zero_s[Lat-2]) begin
				psi_s63 <= dau_pkg::PSI_MIN;
			end else begin
				psi_s63 <= psi_rnd[55:8];
			end
		end
	end

	logic inval_s63;

	always_ff @(posedge clk) begin
		if (adv) begin
			inval_s63 <= zero_s[Lat-2];
		end
	end

	assign m_axis_tvalid   = vld_s[Lat-1];
	assign m_axis_tdata    = psi_s63;
	assign m_axis_tuser[0] = inval_s63;

endmodule

@@ tb/digamma_asymptotic_unit_tb.sv @@
// Self-checking stream testbench for the digamma evaluation pipeline.
`timescale 1ns / 1ps

module digamma_asymptotic_unit_tb;

	localparam int LIMIT_CYCLES = 300000;
	localparam int HOLD_CYCLES  = 300;

	// Bit-exact digamma of one Q16.16 argument, given as Q24.
	function automatic longint rshift_round(longint v, int n);
		return (v + (longint'(1) << (n - 1))) >>> n;
	endfunction

	function automatic longint recip_q32(longint unsigned num, longint unsigned d);
		return longint'((num + (d >> 1)) / d);
	endfunction

	function automatic longint log_q32(longint unsigned s);
		int e;
		longint unsigned m, f, t;
		e = 0;
		f = 0;
		for (int i = 0; i < 40; i++) begin
			if (s[i]) e = i;
		end
		m = (e > 31) ? (s >> (e - 31)) : (s << (31 - e));
		for (int i = 0; i < dau_pkg::LN_ROUNDS; i++) begin
			m = (m * m) >> 31;
			if (m >= (64'd1 << 32)) begin
				m = m >> 1;
				f[31 - i] = 1'b1;
			end
		end
		t = (f * longint'(dau_pkg::LN2_Q32) + (64'd1 << 31)) >> 32;
		return longint'(e - 16) * longint'(dau_pkg::LN2_Q32) + longint'(t);
	endfunction

	function automatic logic [dau_pkg::PSI_W-1:0] digamma_q24(logic [dau_pkg::X_W-1:0] x);
		longint unsigned s;
		longint inv, half, q, poly, psi;
		s = longint'(x) + 6 * longint'(dau_pkg::ONE_Q16);
		inv = recip_q32(64'd1 << 48, s);
		half = recip_q32(64'd1 << 47, s);
		q = rshift_round(inv * inv, 32);
		poly = longint'(dau_pkg::COEF_C4);
		poly = rshift_round(poly * q, 32) - longint'(dau_pkg::COEF_C3);
		poly = rshift_round(poly * q, 32) + longint'(dau_pkg::COEF_C2);
		poly = rshift_round(poly * q, 32) - longint'(dau_pkg::COEF_C1);
		poly = rshift_round(poly * q, 32);
		psi = log_q32(s) - half + poly;
		for (int k = 0; k < 6; k++)
			psi -= recip_q32(64'd1 << 48, longint'(x) + k * longint'(dau_pkg::ONE_Q16));
		psi = rshift_round(psi, 8);
		return psi[dau_pkg::PSI_W-1:0];
	endfunction

	typedef struct packed {
		logic [dau_pkg::PSI_W-1:0] psi;
		logic                      invalid;
	} psi_result_t;

	class digamma_scoreboard;
		psi_result_t pending[$];
		int failures;

		function void note_argument(logic [dau_pkg::X_W-1:0] x);
			psi_result_t r;
			if (x == '0) begin
				r.psi = dau_pkg::PSI_MIN;
				r.invalid = 1'b1;
			end else begin
				r.psi = digamma_q24(x);
				r.invalid = 1'b0;
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic [dau_pkg::PSI_W-1:0] psi, logic invalid);
			psi_result_t r;
			if (pending.size() == 0) begin
				$error("unexpected result psi_value=%h invalid=%b", psi, invalid);
				failures++;
				return;
			end
			r = pending.pop_front();
			if (psi !== r.psi) begin
				$error("psi_value: expected %h, actual %h", r.psi, psi);
				failures++;
			end
			if (invalid !== r.invalid) begin
				$error("invalid: expected %b, actual %b", r.invalid, invalid);
				failures++;
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       s_axis_tvalid;
	logic                       s_axis_tready;
	logic [dau_pkg::X_W-1:0]    s_axis_tdata;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready;
	logic [dau_pkg::PSI_W-1:0]  m_axis_tdata;
	logic [0:0]                 m_axis_tuser;

	digamma_scoreboard psi_board;
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_request;
	int  cycle_count = 0;

	digamma_asymptotic_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) psi_board.note_argument(s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			psi_board.check_result(m_axis_tdata, m_axis_tuser[0]);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// The receiver stalls at random, or holds off entirely for a long stretch on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_argument(logic [dau_pkg::X_W-1:0] x);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= x;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	function automatic logic [dau_pkg::X_W-1:0] random_argument();
		case ($urandom_range(9))
			0:       return '0;
			1, 2:    return $urandom_range(255);
			3, 4:    return $urandom_range(32'h000F_FFFF);
			5:       return $urandom_range(32'h00FF_FFFF) << 8;
			6:       return 32'hFFFF_FFFF - $urandom_range(32'h0000_FFFF);
			default: return $urandom;
		endcase
	endfunction

	task automatic run_phase(int idle_pct, int stall_pct, int count);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) send_argument(random_argument());
		s_axis_tvalid <= 1'b0;
		while (psi_board.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic [dau_pkg::X_W-1:0] corner_args[$];
		psi_board      = new();
		hold_request   = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		m_axis_tready  = 1'b0;
		corner_args = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_8000,
			32'h0000_FFFF, 32'h0001_0000, 32'h0002_0000, 32'h0006_0000,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h8000_0000,
			32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0000_0000};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (corner_args[i]) send_argument(corner_args[i]);
		s_axis_tvalid <= 1'b0;
		while (psi_board.pending.size() != 0) @(posedge clk);
		run_phase(0, 0, 140);
		run_phase(62, 0, 140);
		run_phase(0, 62, 140);
		run_phase(27, 27, 140);
		// Long hold-off at the output while requests keep coming, so the pipeline backs up.
		hold_request = 1'b1;
		run_phase(0, 10, 140);
		repeat (dau_pkg::PIPE_LAT + 10) @(posedge clk);
		if (psi_board.failures == 0 && psi_board.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
